[rtl/cau_pkg.sv]
// cau_pkg: shared constants for the complex arithmetic unit
// default data widths and command codes; no dependencies
package cau_pkg;

  localparam int DATA_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF  = 8;
  localparam int CMD_WIDTH      = 3;

  typedef enum logic [CMD_WIDTH-1:0] {
    CMD_ADD = 3'd0,
    CMD_SUB = 3'd1,
    CMD_MUL = 3'd2,
    CMD_DIV = 3'd3,
    CMD_MAG = 3'd4
  } cmd_t;

endpackage

[rtl/cau_divider.sv]
// cau_divider: pipelined restoring divider, real and imaginary numerators over one divisor
// one quotient bit per stage; depends on cau_pkg for default widths
module cau_divider #(
  parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic [2*DATA_WIDTH+FRAC_BITS-1:0]     adv,
  input  logic [2*DATA_WIDTH-1:0]               num_re,
  input  logic [2*DATA_WIDTH-1:0]               num_im,
  input  logic [2*DATA_WIDTH-1:0]               den,
  output logic [DATA_WIDTH:0]                   quo_re,
  output logic [DATA_WIDTH:0]                   quo_im
);

  localparam int W      = DATA_WIDTH;
  localparam int PW     = 2 * DATA_WIDTH;
  localparam int NW     = PW + FRAC_BITS;
  localparam int STAGES = NW;
  localparam logic [W:0] HALF = (W+1)'(1) << (W - 1);

  typedef struct packed {
    logic [PW-1:0] r;
    logic [NW-1:0] n;
    logic [W:0]    q;
    logic          b;
  } div_t;

  div_t          st_re [STAGES];
  div_t          st_im [STAGES];
  div_t          nx_re [STAGES];
  div_t          nx_im [STAGES];
  logic [PW-1:0] d     [STAGES];
  logic [PW-1:0] nd    [STAGES];

  function automatic div_t div_step(div_t s, logic [PW-1:0] t);
    logic [PW:0] r2;
    logic        ge;
    div_t        o;
    r2  = {s.r, s.n[NW-1]};
    ge  = (r2 >= {1'b0, t});
    o.r = ge ? PW'(r2 - {1'b0, t}) : r2[PW-1:0];
    o.n = {s.n[NW-2:0], 1'b0};
    o.q = {s.q[W-1:0], ge};
    o.b = s.b | s.q[W];
    return o;
  endfunction

  // quotients above half range all clip the same way
  function automatic logic [W:0] cap_fn(div_t s);
    if (s.b || (s.q > HALF)) begin
      return HALF + (W+1)'(1);
    end
    return s.q;
  endfunction

  always_comb begin
    div_t          src_re;
    div_t          src_im;
    logic [PW-1:0] den_j;
    for (int j = 0; j < STAGES; j++) begin
      if (j == 0) begin
        src_re.r = '0;
        src_re.n = NW'(num_re) << FRAC_BITS;
        src_re.q = '0;
        src_re.b = 1'b0;
        src_im.r = '0;
        src_im.n = NW'(num_im) << FRAC_BITS;
        src_im.q = '0;
        src_im.b = 1'b0;
        den_j    = den;
      end else begin
        src_re = st_re[j-1];
        src_im = st_im[j-1];
        den_j  = d[j-1];
      end
      nx_re[j] = div_step(src_re, den_j);
      nx_im[j] = div_step(src_im, den_j);
      nd[j]    = den_j;
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < STAGES; j++) begin
      if (adv[j]) begin
        st_re[j] <= nx_re[j];
        st_im[j] <= nx_im[j];
        d[j]     <= nd[j];
      end
    end
  end

  assign quo_re = cap_fn(st_re[STAGES-1]);
  assign quo_im = cap_fn(st_im[STAGES-1]);

endmodule

[rtl/complex_arithmetic_unit.sv]
// complex_arithmetic_unit: top level of the pipelined complex number unit
// depends on cau_pkg and cau_divider
//
// Takes one transfer per cycle, while in_stall is low, of two signed fixed-point complex
// operands (Q8.8 by default) and a command (add, subtract, multiply, divide a/b,
// magnitude of a) and returns one result per item, in order. Its depth is set by the
// restoring divider, which resolves one quotient bit per pipeline stage; the magnitude
// square root runs alongside it, one root bit per stage for the first DATA_WIDTH stages.
// Sustained rate is one item per cycle while out_stall is low. Each stage carries its own
// valid bit and only holds while the stage after it is full and held, so bubbles close up
// under a downstream stall and in_stall rises only when the whole pipeline is full. Add,
// subtract and multiply saturate to the signed range and set saturated; multiply and
// divide truncate toward zero. A divide by zero returns zero with divide_by_zero set.
// magnitude is an unsigned square root with FRAC_BITS fraction bits and is zero for every
// command but magnitude. Codes 5 to 7 return all zeros. No state is kept between items.
module complex_arithmetic_unit #(
  parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [cau_pkg::CMD_WIDTH-1:0] command,
  input  logic signed [DATA_WIDTH-1:0] a_real,
  input  logic signed [DATA_WIDTH-1:0] a_imag,
  input  logic signed [DATA_WIDTH-1:0] b_real,
  input  logic signed [DATA_WIDTH-1:0] b_imag,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [DATA_WIDTH-1:0] out_real,
  output logic signed [DATA_WIDTH-1:0] out_imag,
  output logic [DATA_WIDTH-1:0]        magnitude,
  output logic                         saturated,
  output logic                         divide_by_zero
);

  localparam int W  = DATA_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int PW = 2 * DATA_WIDTH;
  localparam int IT = PW + FRAC_BITS;   // iteration stages
  localparam int NS = IT + 4;           // all stages with valid bits
  localparam logic [PW-1:0] HALF_P = PW'(1) << (W - 1);
  localparam logic [PW-1:0] MAX_P  = HALF_P - PW'(1);

  typedef struct packed {
    logic [cau_pkg::CMD_WIDTH-1:0] cmd;
    logic                          neg_re;
    logic                          neg_im;
    logic [W-1:0]                  pre_re;
    logic [W-1:0]                  pre_im;
    logic                          pre_sat;
    logic                          dz;
  } tag_t;

  typedef struct packed {
    logic [PW-1:0] rad;
    logic [W+1:0]  rem;
    logic [W-1:0]  root;
  } sq_t;

  // stage valid bits and per-stage advance
  logic [NS-1:0] v;
  logic [NS-1:0] adv;

  assign adv[NS-1] = !v[NS-1] || !out_stall;
  for (genvar k = 0; k < NS - 1; k++) begin : g_adv
    assign adv[k] = !v[k] || adv[k+1];
  end

  assign in_stall  = !adv[0];
  assign out_valid = v[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[0]) v[0] <= in_valid;
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) v[k] <= v[k-1];
      end
    end
  end

  // saturate a sign/magnitude value; returns {sat, value}
  function automatic logic [W:0] clip_fn(logic neg, logic [PW-1:0] mag);
    logic [PW-1:0] nm;
    nm = -mag;
    if (!neg) begin
      if (mag > MAX_P) return {1'b1, MAX_P[W-1:0]};
      return {1'b0, mag[W-1:0]};
    end
    if (mag > HALF_P) return {1'b1, HALF_P[W-1:0]};
    return {1'b0, nm[W-1:0]};
  endfunction

  // stage 0: input register
  logic [cau_pkg::CMD_WIDTH-1:0] cmd0;
  logic signed [W-1:0]           ar0, ai0, br0, bi0;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      cmd0 <= command;
      ar0  <= a_real;
      ai0  <= a_imag;
      br0  <= b_real;
      bi0  <= b_imag;
    end
  end

  // stage 1: products, squares, add/subtract
  logic [cau_pkg::CMD_WIDTH-1:0] cmd1;
  logic signed [PW-1:0]          p_rr, p_ii, p_ri, p_ir, sq_x, sq_y;
  logic signed [W:0]             sum_re1, sum_im1;
  logic signed [W-1:0]           mx, my;

  // the squares serve the divisor norm or the magnitude radicand
  assign mx = (cmd0 == cau_pkg::CMD_MAG) ? ar0 : br0;
  assign my = (cmd0 == cau_pkg::CMD_MAG) ? ai0 : bi0;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      cmd1 <= cmd0;
      p_rr <= ar0 * br0;
      p_ii <= ai0 * bi0;
      p_ri <= ar0 * bi0;
      p_ir <= ai0 * br0;
      sq_x <= mx * mx;
      sq_y <= my * my;
      if (cmd0 == cau_pkg::CMD_SUB) begin
        sum_re1 <= ar0 - br0;
        sum_im1 <= ai0 - bi0;
      end else begin
        sum_re1 <= ar0 + br0;
        sum_im1 <= ai0 + bi0;
      end
    end
  end

  // stage 2: cross sums to sign/magnitude, norm, early clipping
  logic                is_div;
  logic signed [PW:0]  s_re, s_im, abs_re, abs_im;
  logic signed [W:0]   abs_are, abs_aim;
  logic                n_re, n_im;
  logic [PW-1:0]       m_re, m_im, t_c;
  logic [W:0]          c_re, c_im;

  assign is_div  = (cmd1 == cau_pkg::CMD_DIV);
  assign s_re    = is_div ? p_rr + p_ii : p_rr - p_ii;
  assign s_im    = is_div ? p_ir - p_ri : p_ri + p_ir;
  assign n_re    = s_re[PW];
  assign n_im    = s_im[PW];
  assign abs_re  = n_re ? -s_re : s_re;
  assign abs_im  = n_im ? -s_im : s_im;
  assign m_re    = abs_re[PW-1:0];
  assign m_im    = abs_im[PW-1:0];
  assign t_c     = sq_x[PW-1:0] + sq_y[PW-1:0];
  assign abs_are = sum_re1[W] ? -sum_re1 : sum_re1;
  assign abs_aim = sum_im1[W] ? -sum_im1 : sum_im1;

  always_comb begin
    if (cmd1 == cau_pkg::CMD_MUL) begin
      c_re = clip_fn(n_re, m_re >> F);
      c_im = clip_fn(n_im, m_im >> F);
    end else begin
      c_re = clip_fn(sum_re1[W], PW'($unsigned(abs_are)));
      c_im = clip_fn(sum_im1[W], PW'($unsigned(abs_aim)));
    end
  end

  tag_t          tag2;
  logic [PW-1:0] mag_re2, mag_im2, t2;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      tag2.cmd     <= cmd1;
      tag2.neg_re  <= n_re;
      tag2.neg_im  <= n_im;
      tag2.pre_re  <= c_re[W-1:0];
      tag2.pre_im  <= c_im[W-1:0];
      tag2.pre_sat <= c_re[W] | c_im[W];
      tag2.dz      <= is_div && (t_c == '0);
      mag_re2      <= m_re;
      mag_im2      <= m_im;
      t2           <= t_c;
    end
  end

  // iteration stages: divider bits and square root bits
  logic [W:0] quo_re, quo_im;

  cau_divider #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_div (
    .clk    (clk),
    .adv    (adv[3 +: IT]),
    .num_re (mag_re2),
    .num_im (mag_im2),
    .den    (t2),
    .quo_re (quo_re),
    .quo_im (quo_im)
  );

  tag_t tg    [IT];
  sq_t  sq    [IT];
  sq_t  sq_nx [IT];

  function automatic sq_t sq_step(sq_t s);
    logic [W+3:0] remw;
    logic [W+3:0] trial;
    logic         ge;
    sq_t          o;
    remw   = {s.rem, s.rad[PW-1:PW-2]};
    trial  = (W+4)'({s.root, 2'b01});
    ge     = (remw >= trial);
    o.rem  = ge ? (W+2)'(remw - trial) : remw[W+1:0];
    o.root = {s.root[W-2:0], ge};
    o.rad  = s.rad << 2;
    return o;
  endfunction

  always_comb begin
    sq_t src;
    for (int j = 0; j < IT; j++) begin
      if (j == 0) begin
        src.rad  = t2;
        src.rem  = '0;
        src.root = '0;
      end else begin
        src = sq[j-1];
      end
      if (j < W) sq_nx[j] = sq_step(src);
      else       sq_nx[j] = src;
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < IT; j++) begin
      if (adv[3+j]) begin
        tg[j] <= (j == 0) ? tag2 : tg[j-1];
        sq[j] <= sq_nx[j];
      end
    end
  end

  // output stage: command select and divide clipping
  tag_t         tl;
  logic [W:0]   d_re, d_im;
  logic [W-1:0] o_re, o_im, o_mag;
  logic         o_sat, o_dz;

  assign tl   = tg[IT-1];
  assign d_re = clip_fn(tl.neg_re, PW'(quo_re));
  assign d_im = clip_fn(tl.neg_im, PW'(quo_im));

  always_comb begin
    o_re  = '0;
    o_im  = '0;
    o_mag = '0;
    o_sat = 1'b0;
    o_dz  = 1'b0;
    unique case (tl.cmd)
      cau_pkg::CMD_ADD, cau_pkg::CMD_SUB, cau_pkg::CMD_MUL: begin
        o_re  = tl.pre_re;
        o_im  = tl.pre_im;
        o_sat = tl.pre_sat;
      end
      cau_pkg::CMD_DIV: begin
        if (tl.dz) begin
          o_dz = 1'b1;
        end else begin
          o_re  = d_re[W-1:0];
          o_im  = d_im[W-1:0];
          o_sat = d_re[W] | d_im[W];
        end
      end
      cau_pkg::CMD_MAG: begin
        o_mag = sq[IT-1].root;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv[NS-1]) begin
      out_real       <= o_re;
      out_imag       <= o_im;
      magnitude      <= o_mag;
      saturated      <= o_sat;
      divide_by_zero <= o_dz;
    end
  end

  // a zero divisor result carries nothing else
  a_dz_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && divide_by_zero |-> !saturated && out_real == '0 && out_imag == '0)
    else $error("divide by zero result not cleared");

  // magnitude results leave the complex parts empty
  a_mag_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && magnitude != '0 |-> !saturated && out_real == '0 && out_imag == '0)
    else $error("magnitude result mixed with complex result");

  // an accepted transfer always lands in the input stage
  a_in_lands: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> v[0])
    else $error("accepted transfer lost at input stage");

  // a held stage keeps its item and its divisor
  a_hold: assert property (@(posedge clk) disable iff (rst)
    v[2] && !adv[2] |=> v[2] && $stable(t2) && $stable(tag2))
    else $error("held stage changed");

endmodule

[sim/complex_arithmetic_unit_tb.sv]
// complex_arithmetic_unit_tb: self-checking testbench for the complex arithmetic unit
// predicts add/sub/mul/div/magnitude results in order and checks each output transfer
// depends on cau_pkg and complex_arithmetic_unit
`timescale 1ns / 1ps

module complex_arithmetic_unit_tb;

  localparam int W = 16;
  localparam int FB = 8;
  localparam int LATENCY = 2 * W + FB + 4;
  localparam logic [2:0] CMD_UNDEF = 3'd5;
  localparam logic [2:0] CMD_UNDEF_HI = 3'd7;

  typedef struct packed {
    logic signed [W-1:0] re;
    logic signed [W-1:0] im;
    logic [W-1:0]        mag;
    logic                sat;
    logic                dz;
  } cau_result_t;

  // ---------------------------------------------------------------------------
  // arithmetic predictor
  // ---------------------------------------------------------------------------

  // clip a sign/magnitude value to the signed range, flag if clipped
  function automatic logic signed [W-1:0] clip_sm(input bit neg, input longint unsigned m,
                                                  inout bit sat);
    longint unsigned half;
    half = 64'd1 << (W - 1);
    if (!neg) begin
      if (m > half - 1) begin
        sat = 1;
        return W'(half - 1);
      end
      return W'(m);
    end
    if (m > half) begin
      sat = 1;
      return W'(-half);
    end
    return W'(-longint'(m));
  endfunction

  // floor(m * 2^FB / t), capped just above the signed range
  function automatic longint unsigned scaled_quot(input longint unsigned m,
                                                  input longint unsigned t);
    longint unsigned q, r, half;
    half = 64'd1 << (W - 1);
    q = m / t;
    r = m % t;
    if (q > half) return half + 1;
    for (int i = 0; i < FB; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= t) begin
        r -= t;
        q |= 1;
      end
      if (q > half) return half + 1;
    end
    return q;
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned s);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= res + b) begin
        s -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned abs64(input longint x);
    return x < 0 ? -x : x;
  endfunction

  function automatic cau_result_t predict_complex(input logic [2:0] cmd,
                                                  input logic signed [W-1:0] ar,
                                                  input logic signed [W-1:0] ai,
                                                  input logic signed [W-1:0] br,
                                                  input logic signed [W-1:0] bi);
    cau_result_t r;
    longint s1, s2, t;
    longint unsigned m1, m2;
    bit sat;
    r = '0;
    sat = 0;
    case (cmd)
      cau_pkg::CMD_ADD, cau_pkg::CMD_SUB: begin
        s1 = (cmd == cau_pkg::CMD_ADD) ? longint'(ar) + br : longint'(ar) - br;
        s2 = (cmd == cau_pkg::CMD_ADD) ? longint'(ai) + bi : longint'(ai) - bi;
        r.re = clip_sm(s1 < 0, abs64(s1), sat);
        r.im = clip_sm(s2 < 0, abs64(s2), sat);
      end
      cau_pkg::CMD_MUL: begin
        // products fit easily in 64 bits, so the sums are exact
        s1 = longint'(ar) * br - longint'(ai) * bi;
        s2 = longint'(ar) * bi + longint'(ai) * br;
        m1 = abs64(s1) >> FB;
        m2 = abs64(s2) >> FB;
        r.re = clip_sm(s1 < 0 && m1 != 0, m1, sat);
        r.im = clip_sm(s2 < 0 && m2 != 0, m2, sat);
      end
      cau_pkg::CMD_DIV: begin
        t = longint'(br) * br + longint'(bi) * bi;
        if (t == 0) begin
          r.dz = 1;
        end else begin
          s1 = longint'(ar) * br + longint'(ai) * bi;
          s2 = longint'(ai) * br - longint'(ar) * bi;
          m1 = scaled_quot(abs64(s1), t);
          m2 = scaled_quot(abs64(s2), t);
          r.re = clip_sm(s1 < 0 && m1 != 0, m1, sat);
          r.im = clip_sm(s2 < 0 && m2 != 0, m2, sat);
        end
      end
      cau_pkg::CMD_MAG: r.mag = W'(int_sqrt(longint'(ar) * ar + longint'(ai) * ai));
      default: ;
    endcase
    r.sat = sat;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // scoreboard: in-order queue of predicted results
  // ---------------------------------------------------------------------------
  class cau_scoreboard;
    cau_result_t pending[$];
    int errors;

    function void note_input(logic [2:0] cmd, logic signed [W-1:0] ar,
                             logic signed [W-1:0] ai, logic signed [W-1:0] br,
                             logic signed [W-1:0] bi);
      pending.push_back(predict_complex(cmd, ar, ai, br, bi));
    endfunction

    function void check_result(cau_result_t got);
      cau_result_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result re=%0d im=%0d", $time, got.re, got.im);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.re !== exp_r.re) begin
        $display("%0t: out_real expected %0d got %0d", $time, exp_r.re, got.re);
        errors++;
      end
      if (got.im !== exp_r.im) begin
        $display("%0t: out_imag expected %0d got %0d", $time, exp_r.im, got.im);
        errors++;
      end
      if (got.mag !== exp_r.mag) begin
        $display("%0t: magnitude expected %0d got %0d", $time, exp_r.mag, got.mag);
        errors++;
      end
      if (got.sat !== exp_r.sat) begin
        $display("%0t: saturated expected %0b got %0b", $time, exp_r.sat, got.sat);
        errors++;
      end
      if (got.dz !== exp_r.dz) begin
        $display("%0t: divide_by_zero expected %0b got %0b", $time, exp_r.dz, got.dz);
        errors++;
      end
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // dut and clock
  // ---------------------------------------------------------------------------
  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic [cau_pkg::CMD_WIDTH-1:0] command = '0;
  logic signed [W-1:0] a_real = '0, a_imag = '0, b_real = '0, b_imag = '0;
  logic out_valid;
  logic out_stall = 1;
  logic signed [W-1:0] out_real, out_imag;
  logic [W-1:0] magnitude;
  logic saturated, divide_by_zero;

  always #5 clk = ~clk;

  complex_arithmetic_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .a_real(a_real), .a_imag(a_imag),
    .b_real(b_real), .b_imag(b_imag),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_real(out_real), .out_imag(out_imag), .magnitude(magnitude),
    .saturated(saturated), .divide_by_zero(divide_by_zero)
  );

  cau_scoreboard sb = new();
  bit sender_done = 0;
  bit hold_output = 0;   // long receiver hold-off, forced by the sender side
  bit rand_stall = 1;    // zero for stretches with no receiver idling
  int max_gap = 16;

  // ---------------------------------------------------------------------------
  // sender tasks
  // ---------------------------------------------------------------------------

  // offer one item, wait for its transfer, then drop valid for a random gap, if any
  task automatic send_item(input logic [2:0] cmd, input logic signed [W-1:0] ar,
                           input logic signed [W-1:0] ai, input logic signed [W-1:0] br,
                           input logic signed [W-1:0] bi);
    int gap;
    command <= cmd;
    a_real <= ar;
    a_imag <= ai;
    b_real <= br;
    b_imag <= bi;
    in_valid <= 1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(cmd, ar, ai, br, bi);
    gap = $urandom_range(0, max_gap);
    if (gap != 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // operand drawn with a bias toward edges and small values
  function automatic logic signed [W-1:0] draw_operand();
    case ($urandom_range(0, 9))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return '0;
      3, 4: return $signed(16'($urandom_range(0, 1023))) - 16'sd512;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_random();
    logic [2:0] cmd;
    logic signed [W-1:0] br, bi;
    cmd = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                        : 3'($urandom_range(0, 4));
    br = draw_operand();
    bi = draw_operand();
    if (cmd == cau_pkg::CMD_DIV && $urandom_range(0, 15) == 0) begin
      br = '0;
      bi = '0;
    end
    send_item(cmd, draw_operand(), draw_operand(), br, bi);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // receiver: random stall per result, with an externally forced hold-off
  // ---------------------------------------------------------------------------
  initial begin
    int wait_cycles;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      wait_cycles = rand_stall ? $urandom_range(0, 16) : 0;
      if (hold_output || wait_cycles != 0) begin
        out_stall <= 1;
        repeat (wait_cycles) @(posedge clk);
        while (hold_output) @(posedge clk);
      end
      out_stall <= 0;
      @(posedge clk);
      // out_stall was low going into this edge
      if (out_valid && !out_stall)
        sb.check_result('{out_real, out_imag, magnitude, saturated, divide_by_zero});
    end
  end

  // long receiver hold-off during the back-to-back stretch, counted here
  initial begin
    wait (!sender_done && max_gap == 0);
    @(posedge clk);
    hold_output <= 1;
    repeat (200) @(posedge clk);
    hold_output <= 0;
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: extremes, every command, saturation, truncation, zero divisor
    send_item(cau_pkg::CMD_ADD, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000);
    send_item(cau_pkg::CMD_ADD, 16'sh0100, -16'sh0100, 16'sh0080, 16'sh0080);
    send_item(cau_pkg::CMD_SUB, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000);
    send_item(cau_pkg::CMD_SUB, 16'sh0000, 16'sh0000, 16'sh8000, 16'sh0001);
    send_item(cau_pkg::CMD_MUL, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000);
    send_item(cau_pkg::CMD_MUL, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send_item(cau_pkg::CMD_MUL, -16'sh0001, 16'sh0000, 16'sh0001, 16'sh0000);
    send_item(cau_pkg::CMD_MUL, 16'sh0180, 16'sh0040, -16'sh0120, 16'sh0033);
    send_item(cau_pkg::CMD_DIV, 16'sh0100, 16'sh0000, 16'sh0000, 16'sh0000);
    send_item(cau_pkg::CMD_DIV, 16'sh7fff, 16'sh7fff, 16'sh0001, 16'sh0000);
    send_item(cau_pkg::CMD_DIV, 16'sh8000, 16'sh8000, 16'sh0000, -16'sh0001);
    send_item(cau_pkg::CMD_DIV, -16'sh0001, 16'sh0001, 16'sh0300, 16'sh0000);
    send_item(cau_pkg::CMD_DIV, 16'sh0100, 16'sh0200, 16'sh8000, 16'sh7fff);
    send_item(cau_pkg::CMD_MAG, 16'sh8000, 16'sh8000, 16'sh1234, 16'sh5678);
    send_item(cau_pkg::CMD_MAG, 16'sh7fff, 16'sh0000, 16'sh0000, 16'sh0000);
    send_item(cau_pkg::CMD_MAG, 16'sh0300, -16'sh0400, 16'sh0000, 16'sh0000);
    send_item(cau_pkg::CMD_MAG, 16'sh0000, 16'sh0000, 16'sh7fff, 16'sh7fff);
    send_item(CMD_UNDEF, 16'sh7fff, 16'sh8000, 16'sh1111, 16'sh2222);
    send_item(CMD_UNDEF_HI, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000);

    // random with gaps, then back-to-back against the long receiver hold-off
    for (int i = 0; i < 400; i++) send_random();
    max_gap = 0;
    for (int i = 0; i < 300; i++) send_random();
    max_gap = 16;

    // sender pauses until every result is back
    drain();

    // stretch with no idling on either side
    rand_stall = 0;
    max_gap = 0;
    for (int i = 0; i < 250; i++) send_random();
    rand_stall = 1;
    max_gap = 16;
    for (int i = 0; i < 450; i++) send_random();

    drain();
    sender_done = 1;
    repeat (LATENCY + 10) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  // run limit: far above the slowest correct run
  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
